>>> hw/rtl/cppi_pkg.sv
`default_nettype none

package cppi_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned BITS_W    = 6;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned GAP_W     = 10;
  localparam int unsigned MAX_COUNT = 255;
  localparam int unsigned MAX_GAP   = 1000;
  localparam int unsigned NSLOT     = 3;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned IDX_W     = 2;

  typedef enum logic [1:0] {
    KIND_WORD  = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_WIDE  = 3'd1,
    ERR_DESC  = 3'd2,
    ERR_GAP   = 3'd3,
    ERR_COUNT = 3'd4
  } err_t;

  typedef enum logic [IDX_W-1:0] {
    REG_START_BITS = 2'd0,
    REG_END_BITS   = 2'd1,
    REG_MIN_START  = 2'd2,
    REG_DROP_WIDE  = 2'd3
  } reg_t;

  typedef struct packed {
    logic [BITS_W-1:0] start_bits;
    logic [BITS_W-1:0] end_bits;
    logic [DATA_W-1:0] min_start;
    logic              drop_wide;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [DATA_W-1:0]  packed_word;
    logic [DATA_W-1:0]  run_prefix;
    logic [COUNT_W-1:0] chain_count;
    logic [GAP_W-1:0]   zero_gap;
    err_t               error_code;
  } result_t;

  // Up to three results caused by one input word, in emit order.
  typedef struct packed {
    logic    [NSLOT-1:0] vld;
    result_t [NSLOT-1:0] res;
  } record_t;

endpackage

`default_nettype wire

>>> hw/rtl/cppi_front.sv
`default_nettype none

module cppi_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cppi_pkg::cfg_t              cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cppi_pkg::DATA_W-1:0] start_point,
  input  wire logic [cppi_pkg::DATA_W-1:0] end_point,
  input  wire logic                        final_chain,
  input  wire logic                        q_full,
  output logic                             q_push,
  output cppi_pkg::record_t                q_data
);

  // Stage A: per-word packing, no run state involved.
  logic                        a_vld;
  logic                        a_wide;
  logic                        a_fin;
  logic [cppi_pkg::DATA_W-1:0] a_packed;
  logic [cppi_pkg::DATA_W-1:0] a_prefix;

  logic                        a_fire;
  logic                        wide_in;
  logic [cppi_pkg::DATA_W-1:0] end_mask;
  logic [cppi_pkg::DATA_W-1:0] start_mask;
  logic [cppi_pkg::DATA_W-1:0] offset;

  assign a_fire   = a_vld && !q_full;
  assign in_ready = !a_vld || !q_full;

  assign end_mask   = ~({cppi_pkg::DATA_W{1'b1}} << cfg.end_bits);
  assign start_mask = ~({cppi_pkg::DATA_W{1'b1}} << cfg.start_bits);
  assign offset     = start_point - cfg.min_start;
  assign wide_in    = (cfg.start_bits == '0) || ((start_point >> cfg.start_bits) != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (in_ready) begin
      a_vld <= in_valid;
    end
    if (in_valid && in_ready) begin
      a_wide   <= wide_in;
      a_fin    <= final_chain;
      a_packed <= (end_point & end_mask) | ((offset & start_mask) << cfg.end_bits);
      a_prefix <= end_point >> cfg.end_bits;
    end
  end

  // Stage B: run tracking. gap_over/gap_val describe current prefix minus
  // last written entry prefix, less one, so a close needs no subtraction of its own.
  logic [cppi_pkg::DATA_W-1:0] cur, cur_next;
  logic [cppi_pkg::LEN_W-1:0]  len, len_next;
  logic                        run_open, run_open_next;
  logic                        ew, ew_next;
  logic                        gap_over, gap_over_next;
  logic [cppi_pkg::GAP_W-1:0]  gap_val, gap_val_next;
  logic                        halted, halted_next;

  logic [cppi_pkg::DATA_W-1:0] diff;
  logic                        diff_over;
  logic [cppi_pkg::GAP_W-1:0]  diff_gap;

  assign diff      = a_prefix - cur;
  assign diff_over = diff > cppi_pkg::DATA_W'(cppi_pkg::MAX_GAP);
  assign diff_gap  = (diff > cppi_pkg::DATA_W'(1)) ?
                     cppi_pkg::GAP_W'(diff - cppi_pkg::DATA_W'(1)) : '0;

  function automatic cppi_pkg::result_t make_error(input cppi_pkg::err_t code);
    cppi_pkg::result_t r;
    r            = '0;
    r.kind       = cppi_pkg::KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic cppi_pkg::result_t close_run(
    input logic                        written,
    input logic                        over,
    input logic [cppi_pkg::GAP_W-1:0]  gap,
    input logic [cppi_pkg::LEN_W-1:0]  count,
    input logic [cppi_pkg::DATA_W-1:0] prefix
  );
    cppi_pkg::result_t r;
    r = '0;
    if (written && over) begin
      r = make_error(cppi_pkg::ERR_GAP);
    end else if (count > cppi_pkg::LEN_W'(cppi_pkg::MAX_COUNT)) begin
      r = make_error(cppi_pkg::ERR_COUNT);
    end else begin
      r.kind        = cppi_pkg::KIND_ENTRY;
      r.run_prefix  = prefix;
      r.chain_count = count[cppi_pkg::COUNT_W-1:0];
      r.zero_gap    = written ? gap : '0;
    end
    return r;
  endfunction

  always_comb begin
    q_data        = '0;
    cur_next      = cur;
    len_next      = len;
    run_open_next = run_open;
    ew_next       = ew;
    gap_over_next = gap_over;
    gap_val_next  = gap_val;
    halted_next   = halted;
    if (!halted) begin
      if (a_wide && !cfg.drop_wide) begin
        q_data.vld[0] = 1'b1;
        q_data.res[0] = make_error(cppi_pkg::ERR_WIDE);
        halted_next   = 1'b1;
      end else begin
        if (!a_wide) begin
          q_data.vld[0]              = 1'b1;
          q_data.res[0].kind         = cppi_pkg::KIND_WORD;
          q_data.res[0].packed_word  = a_packed;
          if (!run_open) begin
            cur_next      = a_prefix;
            len_next      = cppi_pkg::LEN_W'(1);
            run_open_next = 1'b1;
          end else if (a_prefix == cur) begin
            // saturate one past the limit so the count error still fires
            if (len <= cppi_pkg::LEN_W'(cppi_pkg::MAX_COUNT)) begin
              len_next = len + cppi_pkg::LEN_W'(1);
            end
          end else if (a_prefix < cur) begin
            q_data.vld[1] = 1'b1;
            q_data.res[1] = make_error(cppi_pkg::ERR_DESC);
            halted_next   = 1'b1;
          end else begin
            q_data.vld[1] = 1'b1;
            q_data.res[1] = close_run(ew, gap_over, gap_val, len, cur);
            if (q_data.res[1].kind == cppi_pkg::KIND_ERROR) begin
              halted_next = 1'b1;
            end else begin
              ew_next = 1'b1;
            end
            cur_next      = a_prefix;
            len_next      = cppi_pkg::LEN_W'(1);
            gap_over_next = diff_over;
            gap_val_next  = diff_gap;
          end
        end
        // flush the open run and start a fresh table
        if (a_fin && !halted_next) begin
          if (run_open_next) begin
            q_data.vld[2] = 1'b1;
            q_data.res[2] = close_run(ew_next, gap_over_next, gap_val_next,
                                      len_next, cur_next);
            if (q_data.res[2].kind == cppi_pkg::KIND_ERROR) begin
              halted_next = 1'b1;
            end
          end
          run_open_next = 1'b0;
          len_next      = '0;
          cur_next      = '0;
          ew_next       = 1'b0;
        end
      end
    end
  end

  assign q_push = a_fire && (q_data.vld != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur      <= '0;
      len      <= '0;
      run_open <= 1'b0;
      ew       <= 1'b0;
      gap_over <= 1'b0;
      gap_val  <= '0;
      halted   <= 1'b0;
    end else if (a_fire) begin
      cur      <= cur_next;
      len      <= len_next;
      run_open <= run_open_next;
      ew       <= ew_next;
      gap_over <= gap_over_next;
      gap_val  <= gap_val_next;
      halted   <= halted_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cppi_queue.sv
`default_nettype none

module cppi_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire cppi_pkg::record_t wdata,
  output logic                   full,
  input  wire logic              pop,
  output cppi_pkg::record_t      rdata,
  output logic                   empty
);

  cppi_pkg::record_t           mem [cppi_pkg::QDEPTH];
  logic [cppi_pkg::QPTR_W-1:0] wr_ptr;
  logic [cppi_pkg::QPTR_W-1:0] rd_ptr;
  logic [cppi_pkg::QPTR_W:0]   cnt;

  assign full  = cnt == (cppi_pkg::QPTR_W + 1)'(cppi_pkg::QDEPTH);
  assign empty = cnt == '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + cppi_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + cppi_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + (cppi_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        cnt <= cnt - (cppi_pkg::QPTR_W + 1)'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cppi_back.sv
`default_nettype none

module cppi_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire cppi_pkg::record_t q_rdata,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cppi_pkg::result_t      res,
  output logic                   last_of_run
);

  logic [cppi_pkg::NSLOT-1:0]    hold_vld;
  cppi_pkg::result_t [cppi_pkg::NSLOT-1:0] hold_res;
  logic [1:0]                    sel;
  logic [cppi_pkg::NSLOT-1:0]    rest;
  logic                          accept;
  logic                          load;

  // lowest pending slot goes out first
  always_comb begin
    if (hold_vld[0]) begin
      sel = 2'd0;
    end else if (hold_vld[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  assign rest        = hold_vld & ~(cppi_pkg::NSLOT'(1) << sel);
  assign out_valid   = hold_vld != '0;
  assign res         = hold_res[sel];
  assign last_of_run = rest == '0;
  assign accept      = out_valid && out_ready;
  assign load        = !out_valid || (accept && last_of_run);
  assign q_pop       = load && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= '0;
    end else if (load) begin
      hold_vld <= q_empty ? '0 : q_rdata.vld;
    end else if (accept) begin
      hold_vld <= rest;
    end
    if (q_pop) begin
      hold_res <= q_rdata.res;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/chain_pack_prefix_indexer_unit.sv
// Channel | Direction | Handshake          | Word
// --------+-----------+--------------------+-----------------------------------------
// in      | input     | in_valid/in_ready  | start_point, end_point, final_chain
// out     | output    | out_valid/out_ready| kind, packed_word, run_prefix,
//         |           |                    | chain_count, zero_gap, error_code, last_of_run
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Accepts one input word per cycle while the queue has room; each result takes
// one output cycle, so an input causing two or three results holds the out
// channel for all of them. The first result word passes the pack register, the
// queue write by the run-tracking logic and the output hold register before it
// is valid; the run-state update sets the rate. Synchronous active-high reset
// clears run state, the halt flag and the queue, and loads register defaults.
// A stalled out side fills the four-record queue, after which in_ready drops;
// the input side never blocks results already queued.
`default_nettype none

module chain_pack_prefix_indexer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [cppi_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [cppi_pkg::DATA_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cppi_pkg::DATA_W-1:0]   start_point,
  input  wire logic [cppi_pkg::DATA_W-1:0]   end_point,
  input  wire logic                          final_chain,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         kind,
  output logic [cppi_pkg::DATA_W-1:0]        packed_word,
  output logic [cppi_pkg::DATA_W-1:0]        run_prefix,
  output logic [cppi_pkg::COUNT_W-1:0]       chain_count,
  output logic [cppi_pkg::GAP_W-1:0]         zero_gap,
  output logic [2:0]                         error_code,
  output logic                               last_of_run
);

  cppi_pkg::cfg_t    cfg;
  cppi_pkg::record_t q_wdata;
  cppi_pkg::record_t q_rdata;
  cppi_pkg::result_t res;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;

  // Register file: write-only, taken whenever cfg_we is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_bits <= cppi_pkg::BITS_W'(40);
      cfg.end_bits   <= cppi_pkg::BITS_W'(16);
      cfg.min_start  <= '0;
      cfg.drop_wide  <= 1'b0;
    end else if (cfg_we) begin
      case (cppi_pkg::reg_t'(cfg_index))
        cppi_pkg::REG_START_BITS: cfg.start_bits <= cfg_data[cppi_pkg::BITS_W-1:0];
        cppi_pkg::REG_END_BITS:   cfg.end_bits   <= cfg_data[cppi_pkg::BITS_W-1:0];
        cppi_pkg::REG_MIN_START:  cfg.min_start  <= cfg_data;
        cppi_pkg::REG_DROP_WIDE:  cfg.drop_wide  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front: pack, classify against the open run, queue the results.
  cppi_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_point (start_point),
    .end_point   (end_point),
    .final_chain (final_chain),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // Decouple the two sides so either may stall alone.
  cppi_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back: drain each record one result word at a time.
  cppi_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res         (res),
    .last_of_run (last_of_run)
  );

  assign kind        = res.kind;
  assign packed_word = res.packed_word;
  assign run_prefix  = res.run_prefix;
  assign chain_count = res.chain_count;
  assign zero_gap    = res.zero_gap;
  assign error_code  = res.error_code;

endmodule

`default_nettype wire

>>> hw/rtl/cppi_checker.sv
`default_nettype none

module cppi_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [1:0]                    kind,
  input wire logic [cppi_pkg::DATA_W-1:0]   packed_word,
  input wire logic [cppi_pkg::DATA_W-1:0]   run_prefix,
  input wire logic [cppi_pkg::COUNT_W-1:0]  chain_count,
  input wire logic [cppi_pkg::GAP_W-1:0]    zero_gap,
  input wire logic [2:0]                    error_code,
  input wire logic                          last_of_run
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(packed_word)
      && $stable(run_prefix) && $stable(chain_count) && $stable(zero_gap)
      && $stable(error_code) && $stable(last_of_run))
    else $error("stalled result word changed");

  // an error ends the result group of its input
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == cppi_pkg::KIND_ERROR |-> last_of_run)
    else $error("error result not last of its group");

  // only error words carry an error code
  a_code_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != cppi_pkg::KIND_ERROR |-> error_code == cppi_pkg::ERR_NONE)
    else $error("error code on a non-error word");

  // halt after a delivered error: nothing more until reset
  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && kind == cppi_pkg::KIND_ERROR |=> !out_valid)
    else $error("result after error");

endmodule

bind chain_pack_prefix_indexer_unit cppi_checker u_cppi_checker (.*);

`default_nettype wire
